// File: rtl/qrs_pkg.sv
package qrs_pkg;

    // Default fraction width of the Q format
    localparam int FRAC_BITS = 16;

    // Field and datapath widths fixed by the 32-bit coefficients
    localparam int COEF_W  = 32;
    localparam int TOL_W   = 16;
    localparam int NUM_W   = 35;
    localparam int DEN_W   = 33;
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int PROD_W  = 64;
    localparam int DISC_W  = 65;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    // Root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    // Equation class decided after the discriminant
    typedef enum logic [2:0] {
        K_DEGEN,
        K_LINEAR,
        K_DOUBLE,
        K_NEG,
        K_TWO
    } t_kind;

    // Request data carried alongside the square root
    typedef struct packed {
        t_kind                    kind;
        logic                     c_zero;
        logic signed [NUM_W-1:0]  num_base;
        logic signed [NUM_W-1:0]  neg_b;
        logic signed [DEN_W-1:0]  den;
    } t_side;

    // Sign and zero-divisor flags of the two quotients
    typedef struct packed {
        logic dz;
        logic nn_p;
        logic nn_m;
        logic qn_p;
        logic qn_m;
    } t_dsign;

    // Magnitude of a 32-bit signed value
    function automatic logic [COEF_W:0] mag33(logic signed [COEF_W-1:0] v);
        logic signed [COEF_W:0] e;
        e = {v[COEF_W-1], v};
        return e[COEF_W] ? (COEF_W+1)'(-e) : (COEF_W+1)'(e);
    endfunction

endpackage

// File: rtl/qrs_front.sv
module qrs_front #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic [qrs_pkg::TOL_W-1:0]              i_tol,
    input  logic                                   i_valid,
    input  logic signed [qrs_pkg::COEF_W-1:0]      i_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]      i_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]      i_c,
    output logic                                   o_valid,
    output qrs_pkg::t_side                         o_side,
    output logic [qrs_pkg::RAD_W-1:0]              o_rad
);

    localparam int CW = qrs_pkg::COEF_W;
    localparam int PW = qrs_pkg::PROD_W;
    localparam int EW = qrs_pkg::DISC_W;
    localparam logic signed [EW-1:0] LIM = 65'sh0_2000_0000_0000_0000;

    // Stage A: zero tests and products
    logic                 r_va;
    logic signed [CW-1:0] r_a, r_b, r_c;
    logic                 r_nza_a, r_nzb_a, r_nzc_a;
    logic [PW-1:0]        r_bb;
    logic signed [PW-1:0] r_ac;
    logic [CW:0]          mb;
    logic signed [PW-1:0] n_ac;

    assign mb   = qrs_pkg::mag33(i_b);
    assign n_ac = i_a * i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_c     <= i_c;
            r_nza_a <= qrs_pkg::mag33(i_a) < {{(CW+1-qrs_pkg::TOL_W){1'b0}}, i_tol};
            r_nzb_a <= mb < {{(CW+1-qrs_pkg::TOL_W){1'b0}}, i_tol};
            r_nzc_a <= qrs_pkg::mag33(i_c) < {{(CW+1-qrs_pkg::TOL_W){1'b0}}, i_tol};
            r_bb    <= mb[CW-1:0] * mb[CW-1:0];
            r_ac    <= n_ac;
        end
    end

    // Stage B: e = (b*b >> 2) - a*c
    logic                 r_vb;
    logic signed [CW-1:0] r_a_b, r_b_b, r_c_b;
    logic                 r_nza_b, r_nzb_b, r_nzc_b;
    logic signed [EW-1:0] r_e;
    logic [1:0]           r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_b   <= r_a;
            r_b_b   <= r_b;
            r_c_b   <= r_c;
            r_nza_b <= r_nza_a;
            r_nzb_b <= r_nzb_a;
            r_nzc_b <= r_nzc_a;
            r_e     <= $signed({3'b000, r_bb[PW-1:2]}) - $signed({r_ac[PW-1], r_ac});
            r_r     <= r_bb[1:0];
        end
    end

    // Stage C: classify and form numerator, divisor and radicand
    logic                  inlim;
    logic signed [PW-1:0]  d;
    logic [PW-1:0]         magd;
    logic [PW-1:0]         thr;
    logic                  dzero;
    qrs_pkg::t_side        n_side;
    logic [qrs_pkg::RAD_W-1:0] n_rad;

    always_comb begin
        inlim = (r_e < LIM) && (r_e > -LIM);
        d     = $signed({r_e[61:0], r_r});
        magd  = d[PW-1] ? PW'(-d) : PW'(d);
        thr   = PW'(i_tol) << FRAC_BITS;
        dzero = inlim && (magd < thr);

        if (r_nza_b && r_nzb_b) begin
            n_side.kind = qrs_pkg::K_DEGEN;
        end else if (r_nza_b) begin
            n_side.kind = qrs_pkg::K_LINEAR;
        end else if (dzero) begin
            n_side.kind = qrs_pkg::K_DOUBLE;
        end else if (r_e[EW-1]) begin
            n_side.kind = qrs_pkg::K_NEG;
        end else begin
            n_side.kind = qrs_pkg::K_TWO;
        end

        n_side.c_zero = r_nzc_b;
        n_side.neg_b  = -$signed({{3{r_b_b[CW-1]}}, r_b_b});
        if (n_side.kind == qrs_pkg::K_LINEAR) begin
            n_side.num_base = -$signed({{3{r_c_b[CW-1]}}, r_c_b});
            n_side.den      = $signed({r_b_b[CW-1], r_b_b});
        end else begin
            n_side.num_base = n_side.neg_b;
            n_side.den      = $signed({r_a_b, 1'b0});
        end

        n_rad = (n_side.kind == qrs_pkg::K_TWO) ? {r_e[63:0], r_r} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= n_side;
            o_rad  <= n_rad;
        end
    end

endmodule

// File: rtl/qrs_sqrt.sv
module qrs_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  qrs_pkg::t_side                i_side,
    input  logic [qrs_pkg::RAD_W-1:0]     i_rad,
    output logic                          o_valid,
    output qrs_pkg::t_side                o_side,
    output logic [qrs_pkg::ROOT_W-1:0]    o_root
);

    localparam int N  = qrs_pkg::ROOT_W;
    localparam int RW = qrs_pkg::RAD_W;
    localparam int MW = 36;

    logic              w_v    [0:N];
    qrs_pkg::t_side    w_side [0:N];
    logic [RW-1:0]     w_rad  [0:N];
    logic [MW-1:0]     w_rem  [0:N];
    logic [N-1:0]      w_root [0:N];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // One root bit per stage, most significant pair first
    for (genvar k = 0; k < N; k++) begin : g_step
        logic              r_v;
        qrs_pkg::t_side    r_side;
        logic [RW-1:0]     r_rad;
        logic [MW-1:0]     r_rem;
        logic [N-1:0]      r_root;
        logic [MW-1:0]     sh;
        logic [MW-1:0]     trial;
        logic              ge;

        assign sh    = {w_rem[k][MW-3:0], w_rad[k][RW-1:RW-2]};
        assign trial = {1'b0, w_root[k], 2'b01};
        assign ge    = sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
                r_rad  <= {w_rad[k][RW-3:0], 2'b00};
                r_rem  <= ge ? sh - trial : sh;
                r_root <= {w_root[k][N-2:0], ge};
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
    end

    assign o_valid = w_v[N];
    assign o_side  = w_side[N];
    assign o_root  = w_root[N];

endmodule

// File: rtl/qrs_div.sv
module qrs_div #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  qrs_pkg::t_side                             i_side,
    input  logic signed [qrs_pkg::NUM_W-1:0]           i_num_p,
    input  logic signed [qrs_pkg::NUM_W-1:0]           i_num_m,
    input  logic signed [qrs_pkg::DEN_W-1:0]           i_den,
    output logic                                       o_valid,
    output qrs_pkg::t_side                             o_side,
    output qrs_pkg::t_dsign                            o_sign,
    output logic [qrs_pkg::NUM_W-1+FRAC_BITS-1:0]      o_q_p,
    output logic [qrs_pkg::NUM_W-1+FRAC_BITS-1:0]      o_q_m
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int QW = NW - 1 + FRAC_BITS;
    localparam int RW = DW + 1;

    // Prep stage: magnitudes and signs
    logic              r_v0;
    qrs_pkg::t_side    r_side0;
    qrs_pkg::t_dsign   r_sign0;
    logic [DW-1:0]     r_dmag0;
    logic [QW-1:0]     r_dq_p0, r_dq_m0;
    logic [NW-2:0]     mp, mm;

    assign mp = i_num_p[NW-1] ? (NW-1)'(-i_num_p) : (NW-1)'(i_num_p);
    assign mm = i_num_m[NW-1] ? (NW-1)'(-i_num_m) : (NW-1)'(i_num_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side0      <= i_side;
            r_sign0.dz   <= (i_den == '0);
            r_sign0.nn_p <= i_num_p[NW-1];
            r_sign0.nn_m <= i_num_m[NW-1];
            r_sign0.qn_p <= i_num_p[NW-1] != i_den[DW-1];
            r_sign0.qn_m <= i_num_m[NW-1] != i_den[DW-1];
            r_dmag0      <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_dq_p0      <= {mp, {FRAC_BITS{1'b0}}};
            r_dq_m0      <= {mm, {FRAC_BITS{1'b0}}};
        end
    end

    logic              w_v    [0:QW];
    qrs_pkg::t_side    w_side [0:QW];
    qrs_pkg::t_dsign   w_sign [0:QW];
    logic [DW-1:0]     w_dmag [0:QW];
    logic [QW-1:0]     w_dq_p [0:QW];
    logic [QW-1:0]     w_dq_m [0:QW];
    logic [RW-1:0]     w_rm_p [0:QW];
    logic [RW-1:0]     w_rm_m [0:QW];

    assign w_v[0]    = r_v0;
    assign w_side[0] = r_side0;
    assign w_sign[0] = r_sign0;
    assign w_dmag[0] = r_dmag0;
    assign w_dq_p[0] = r_dq_p0;
    assign w_dq_m[0] = r_dq_m0;
    assign w_rm_p[0] = '0;
    assign w_rm_m[0] = '0;

    // Restoring division, one quotient bit per stage on both lanes
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic              r_v;
        qrs_pkg::t_side    r_side;
        qrs_pkg::t_dsign   r_sign;
        logic [DW-1:0]     r_dmag;
        logic [QW-1:0]     r_dq_p, r_dq_m;
        logic [RW-1:0]     r_rm_p, r_rm_m;
        logic [RW-1:0]     sh_p, sh_m, dd;
        logic              ge_p, ge_m;

        assign dd   = {1'b0, w_dmag[k]};
        assign sh_p = {w_rm_p[k][RW-2:0], w_dq_p[k][QW-1]};
        assign sh_m = {w_rm_m[k][RW-2:0], w_dq_m[k][QW-1]};
        assign ge_p = sh_p >= dd;
        assign ge_m = sh_m >= dd;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
                r_sign <= w_sign[k];
                r_dmag <= w_dmag[k];
                r_rm_p <= ge_p ? sh_p - dd : sh_p;
                r_rm_m <= ge_m ? sh_m - dd : sh_m;
                r_dq_p <= {w_dq_p[k][QW-2:0], ge_p};
                r_dq_m <= {w_dq_m[k][QW-2:0], ge_m};
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
        assign w_sign[k+1] = r_sign;
        assign w_dmag[k+1] = r_dmag;
        assign w_dq_p[k+1] = r_dq_p;
        assign w_dq_m[k+1] = r_dq_m;
        assign w_rm_p[k+1] = r_rm_p;
        assign w_rm_m[k+1] = r_rm_m;
    end

    assign o_valid = w_v[QW];
    assign o_side  = w_side[QW];
    assign o_sign  = w_sign[QW];
    assign o_q_p   = w_dq_p[QW];
    assign o_q_m   = w_dq_m[QW];

endmodule

// File: rtl/quadratic_root_solver.sv
// Solves a*x^2 + b*x + c = 0 on a stream of signed Q16.16 coefficient sets, one
// equation accepted per clock while not stalled. Each request yields one result
// through three front stages (products, discriminant, classification), 33
// square-root stages at one root bit each, one numerator stage, a prep stage plus
// 34 + FRAC_BITS restoring-divide stages at one quotient bit each (both roots in
// parallel lanes), and the output register. A stall on the result side freezes
// the whole pipeline and is passed straight back to the request side.
// Write zero_tolerance only while no request is in flight.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qrs_pkg::TOL_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_square,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_linear,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_coef_const,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_root_count,
    output logic signed [qrs_pkg::COEF_W-1:0]   o_root_plus,
    output logic signed [qrs_pkg::COEF_W-1:0]   o_root_minus,
    output logic                                o_overflow
);

    localparam int CW = qrs_pkg::COEF_W;
    localparam int NW = qrs_pkg::NUM_W;
    localparam int QW = NW - 1 + FRAC_BITS;
    localparam logic [CW-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] S_MIN = 32'h8000_0000;

    logic en;
    logic [qrs_pkg::TOL_W-1:0] r_tol;

    // Advance everything unless a finished result is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    logic                          f_v;
    qrs_pkg::t_side                f_side;
    logic [qrs_pkg::RAD_W-1:0]     f_rad;

    qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tol   (r_tol),
        .i_valid (i_valid),
        .i_a     (i_coef_square),
        .i_b     (i_coef_linear),
        .i_c     (i_coef_const),
        .o_valid (f_v),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    logic                          s_v;
    qrs_pkg::t_side                s_side;
    logic [qrs_pkg::ROOT_W-1:0]    s_root;

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_valid (s_v),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    // Numerator stage: -b +/- s for two roots, else the fixed numerator
    logic                   r_nv;
    qrs_pkg::t_side         r_nside;
    logic signed [NW-1:0]   r_num_p, r_num_m;
    logic signed [NW-1:0]   sx;

    assign sx = $signed({2'b00, s_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (en) begin
            r_nv <= s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nside <= s_side;
            r_num_p <= (s_side.kind == qrs_pkg::K_TWO) ? s_side.neg_b + sx
                                                       : s_side.num_base;
            r_num_m <= s_side.neg_b - sx;
        end
    end

    logic                   d_v;
    qrs_pkg::t_side         d_side;
    qrs_pkg::t_dsign        d_sign;
    logic [QW-1:0]          d_q_p, d_q_m;

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nv),
        .i_side  (r_nside),
        .i_num_p (r_num_p),
        .i_num_m (r_num_m),
        .i_den   (r_nside.den),
        .o_valid (d_v),
        .o_side  (d_side),
        .o_sign  (d_sign),
        .o_q_p   (d_q_p),
        .o_q_m   (d_q_m)
    );

    // Saturate quotients and assemble the result
    logic [CW-1:0] rp, rm;
    logic          ov_p, ov_m;
    logic [1:0]    n_cnt;
    logic [CW-1:0] n_rp, n_rm;
    logic          n_ov;

    always_comb begin
        if (d_sign.dz) begin
            rp   = d_sign.nn_p ? S_MIN : S_MAX;
            ov_p = 1'b1;
        end else if (d_sign.qn_p) begin
            ov_p = d_q_p > QW'(S_MIN);
            rp   = ov_p ? S_MIN : CW'(-d_q_p);
        end else begin
            ov_p = d_q_p > QW'(S_MAX);
            rp   = ov_p ? S_MAX : d_q_p[CW-1:0];
        end

        if (d_sign.dz) begin
            rm   = d_sign.nn_m ? S_MIN : S_MAX;
            ov_m = 1'b1;
        end else if (d_sign.qn_m) begin
            ov_m = d_q_m > QW'(S_MIN);
            rm   = ov_m ? S_MIN : CW'(-d_q_m);
        end else begin
            ov_m = d_q_m > QW'(S_MAX);
            rm   = ov_m ? S_MAX : d_q_m[CW-1:0];
        end

        n_rp = '0;
        n_rm = '0;
        n_ov = 1'b0;
        unique case (d_side.kind) inside
            qrs_pkg::K_DEGEN: begin
                n_cnt = d_side.c_zero ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end
            qrs_pkg::K_LINEAR, qrs_pkg::K_DOUBLE: begin
                n_cnt = qrs_pkg::CNT_ONE;
                n_rp  = rp;
                n_ov  = ov_p;
            end
            qrs_pkg::K_TWO: begin
                n_cnt = qrs_pkg::CNT_TWO;
                n_rp  = rp;
                n_rm  = rm;
                n_ov  = ov_p || ov_m;
            end
            default: begin
                n_cnt = qrs_pkg::CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_root_count <= n_cnt;
            o_root_plus  <= $signed(n_rp);
            o_root_minus <= $signed(n_rm);
            o_overflow   <= n_ov;
        end
    end

endmodule

// File: rtl/qrs_checker.sv
module qrs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [1:0]                         o_root_count,
    input logic signed [qrs_pkg::COEF_W-1:0]  o_root_plus,
    input logic signed [qrs_pkg::COEF_W-1:0]  o_root_minus,
    input logic                               o_overflow
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_root_plus) && $stable(o_root_minus))
        else $error("stalled result changed");

    // Push back on requests while a result is held
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("request side not stalled");

    // Second root reads zero unless two roots
    a_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count != qrs_pkg::CNT_TWO |-> o_root_minus == '0)
        else $error("unused second root not zero");

    // No root and no overflow without a finite root
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_INF)
        |-> o_root_plus == '0 && !o_overflow)
        else $error("rootless result carries data");

    // Drop results on reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_root_count (o_root_count),
    .o_root_plus  (o_root_plus),
    .o_root_minus (o_root_minus),
    .o_overflow   (o_overflow)
);
